@@ sv/ecrl_pkg.sv @@
// Shared types and constants for the event coalescing rate limiter.
// No dependencies; imported by every module of the block.
package ecrl_pkg;

    // Held event store
    localparam int MAX_PENDING = 16;
    localparam int PTR_W       = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CNT_W       = $clog2(MAX_PENDING + 1);

    // Command queue between front and back end
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int ID_W    = 8;
    localparam int DATA_W  = 32;
    localparam int DELAY_W = 16;
    localparam int STAT_W  = 32;

    localparam logic [DELAY_W-1:0] MIN_INTERVAL_RESET = DELAY_W'(16);

    // Command decoded by the front end
    typedef enum logic [1:0] {
        OP_POST,
        OP_POST_MERGE,
        OP_WAKE
    } ecrl_op_t;

    // Result kind codes
    localparam logic KIND_WAKE_REQ = 1'b0;
    localparam logic KIND_EVENT    = 1'b1;

    // Queued command
    typedef struct packed {
        ecrl_op_t           op;
        logic [TIME_W-1:0]  now_ms;
        logic [ID_W-1:0]    event_id;
        logic [DATA_W-1:0]  payload;
    } ecrl_item_t;

endpackage

@@ sv/ecrl_front.sv @@
// Front end: takes commands, decodes them and queues them for the back end.
// Depends on ecrl_pkg.
module ecrl_front
    import ecrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                command,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [ID_W-1:0]     event_id,
    input  logic [DATA_W-1:0]   payload,
    input  logic                coalesce,
    output logic                busy,
    output logic                item_valid,
    output ecrl_item_t          item,
    input  logic                pop
);

    ecrl_item_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;
    ecrl_item_t              new_item;
    logic                    push;
    logic                    do_pop;

    function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
            return '0;
        return p + QPTR_W'(1);
    endfunction

    // Decode the command
    always_comb
    begin
        new_item.now_ms   = now_ms;
        new_item.event_id = event_id;
        new_item.payload  = payload;
        priority if (command)
            new_item.op = OP_WAKE;
        else if (coalesce)
            new_item.op = OP_POST_MERGE;
        else
            new_item.op = OP_POST;
    end

    assign busy       = (count_reg == QCNT_W'(QDEPTH));
    assign push       = start && !busy;
    assign item_valid = (count_reg != '0);
    assign do_pop     = pop && item_valid;
    assign item       = entry_reg[rd_ptr_reg];

    // Advance queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= qptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= qptr_inc(rd_ptr_reg);
            if (push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // Store the transfer
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= new_item;
    end

endmodule

@@ sv/ecrl_back.sv @@
// Back end: held event ring, coalescing search, rate check and delivery.
// Depends on ecrl_pkg.
module ecrl_back
    import ecrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DELAY_W-1:0]  min_interval,
    input  logic                item_valid,
    input  ecrl_item_t          item,
    output logic                pop,
    output logic                result_valid,
    output logic                kind,
    output logic [DELAY_W-1:0]  delay_ms,
    output logic [ID_W-1:0]     event_id_res,
    output logic [DATA_W-1:0]   payload_out,
    output logic                last,
    output logic [STAT_W-1:0]   posted_count,
    output logic [STAT_W-1:0]   coalesced_count,
    output logic [STAT_W-1:0]   dropped_count,
    output logic [STAT_W-1:0]   delivered_count
);

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       tail_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   armed_reg;
    logic                   delivered_once_reg;
    logic [TIME_W-1:0]      last_time_reg;
    logic [STAT_W-1:0]      posted_reg;
    logic [STAT_W-1:0]      coalesced_reg;
    logic [STAT_W-1:0]      dropped_reg;
    logic [STAT_W-1:0]      delivered_reg;
    logic                   valid_reg;
    logic                   kind_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic                   last_reg;

    logic [ID_W-1:0]        id_reg [MAX_PENDING];
    logic [DATA_W-1:0]      payload_mem [MAX_PENDING];
    logic [ID_W-1:0]        id_out_reg;
    logic [DATA_W-1:0]      payload_out_reg;

    logic [PTR_W-1:0]       age_idx [MAX_PENDING];
    logic [MAX_PENDING-1:0] age_match;
    logic                   hit;
    logic [PTR_W-1:0]       hit_idx;
    logic                   is_post;
    logic                   merge_hit;
    logic                   full;
    logic [TIME_W-1:0]      elapsed;
    logic                   early;
    logic [DELAY_W-1:0]     delay_calc;
    logic                   mem_we;
    logic [PTR_W-1:0]       mem_waddr;
    logic                   id_we;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(MAX_PENDING - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    // Map each age (0 = oldest) to its ring slot and compare ids
    always_comb
    begin
        logic [PTR_W:0] sum;
        for (int a = 0; a < MAX_PENDING; a++)
        begin
            sum = {1'b0, head_reg} + (PTR_W + 1)'(a);
            if (sum >= (PTR_W + 1)'(MAX_PENDING))
                sum = sum - (PTR_W + 1)'(MAX_PENDING);
            age_idx[a]   = sum[PTR_W-1:0];
            age_match[a] = (CNT_W'(a) < count_reg) && (id_reg[sum[PTR_W-1:0]] == item.event_id);
        end
    end

    // Pick the oldest matching event
    always_comb
    begin
        hit_idx = '0;
        for (int a = MAX_PENDING - 1; a >= 0; a--)
        begin
            if (age_match[a])
                hit_idx = age_idx[a];
        end
    end

    assign hit = |age_match;

    // Rate check against the last delivery
    assign elapsed    = item.now_ms - last_time_reg;
    assign early      = delivered_once_reg && (elapsed < TIME_W'(min_interval));
    assign delay_calc = early ? (min_interval - elapsed[DELAY_W-1:0]) : '0;

    assign pop       = (state_reg == ST_RUN) && item_valid;
    assign is_post   = (item.op != OP_WAKE);
    assign merge_hit = (item.op == OP_POST_MERGE) && hit;
    assign full      = (count_reg == CNT_W'(MAX_PENDING));
    assign mem_we    = pop && is_post;
    assign id_we     = pop && is_post && !merge_hit;
    assign mem_waddr = merge_hit ? hit_idx : tail_reg;

    // Sequence commands, update the ring and register results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_RUN;
            head_reg           <= '0;
            tail_reg           <= '0;
            count_reg          <= '0;
            armed_reg          <= 1'b0;
            delivered_once_reg <= 1'b0;
            last_time_reg      <= '0;
            posted_reg         <= '0;
            coalesced_reg      <= '0;
            dropped_reg        <= '0;
            delivered_reg      <= '0;
            valid_reg          <= 1'b0;
            kind_reg           <= KIND_WAKE_REQ;
            delay_reg          <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                ST_RUN:
                begin
                    if (pop && is_post)
                    begin
                        posted_reg <= posted_reg + STAT_W'(1);
                        if (merge_hit)
                            coalesced_reg <= coalesced_reg + STAT_W'(1);
                        else
                        begin
                            // append, dropping the oldest when full
                            tail_reg <= ptr_inc(tail_reg);
                            if (full)
                            begin
                                head_reg    <= ptr_inc(head_reg);
                                dropped_reg <= dropped_reg + STAT_W'(1);
                            end
                            else
                                count_reg <= count_reg + CNT_W'(1);
                            if (!armed_reg)
                            begin
                                armed_reg <= 1'b1;
                                valid_reg <= 1'b1;
                                kind_reg  <= KIND_WAKE_REQ;
                                delay_reg <= delay_calc;
                                last_reg  <= 1'b1;
                            end
                        end
                    end
                    else if (pop)
                    begin
                        armed_reg <= 1'b0;
                        if (early)
                        begin
                            // re-arm only while events are held
                            if (count_reg != '0)
                            begin
                                armed_reg <= 1'b1;
                                valid_reg <= 1'b1;
                                kind_reg  <= KIND_WAKE_REQ;
                                delay_reg <= delay_calc;
                                last_reg  <= 1'b1;
                            end
                        end
                        else if (count_reg != '0)
                        begin
                            last_time_reg      <= item.now_ms;
                            delivered_once_reg <= 1'b1;
                            delivered_reg      <= delivered_reg + STAT_W'(count_reg);
                            state_reg          <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    // deliver one held event per cycle, oldest first
                    valid_reg <= 1'b1;
                    kind_reg  <= KIND_EVENT;
                    delay_reg <= '0;
                    last_reg  <= (count_reg == CNT_W'(1));
                    head_reg  <= ptr_inc(head_reg);
                    count_reg <= count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                        state_reg <= ST_RUN;
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // Held ids, payload memory and registered delivery read
    always_ff @(posedge clk)
    begin
        if (id_we)
            id_reg[mem_waddr] <= item.event_id;
        if (mem_we)
            payload_mem[mem_waddr] <= item.payload;
        payload_out_reg <= payload_mem[head_reg];
        id_out_reg      <= id_reg[head_reg];
    end

    assign result_valid    = valid_reg;
    assign kind            = kind_reg;
    assign delay_ms        = delay_reg;
    assign last            = last_reg;
    assign event_id_res    = (kind_reg == KIND_EVENT) ? id_out_reg : '0;
    assign payload_out     = (kind_reg == KIND_EVENT) ? payload_out_reg : '0;
    assign posted_count    = posted_reg;
    assign coalesced_count = coalesced_reg;
    assign dropped_count   = dropped_reg;
    assign delivered_count = delivered_reg;

endmodule

@@ sv/event_coalescing_rate_limiter_core.sv @@
// Event coalescing rate limiter, top level. With an idle back end, a wake request
// passes the command queue entry, then the result register; a delivery of N held
// events gives N strobes on consecutive cycles. The back end takes posts and
// wake-ups in its run state and no new command while it drains a delivery; busy
// rises when the 2-entry command queue fills. Reset (async, low) empties the
// store, clears the counters and the armed flag, and sets min_interval to 16.
module event_coalescing_rate_limiter_core
    import ecrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                min_interval_we,
    input  logic [DELAY_W-1:0]  min_interval,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [ID_W-1:0]     event_id,
    input  logic [DATA_W-1:0]   payload,
    input  logic                coalesce,
    output logic                result_valid,
    output logic                kind,
    output logic [DELAY_W-1:0]  delay_ms,
    output logic [ID_W-1:0]     event_id_res,
    output logic [DATA_W-1:0]   payload_out,
    output logic                last,
    output logic [STAT_W-1:0]   posted_count,
    output logic [STAT_W-1:0]   coalesced_count,
    output logic [STAT_W-1:0]   dropped_count,
    output logic [STAT_W-1:0]   delivered_count
);

    logic [DELAY_W-1:0] min_interval_reg;
    logic               item_valid;
    ecrl_item_t         item;
    logic               pop;

    // Hold the configured interval
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_interval_reg <= MIN_INTERVAL_RESET;
        else if (min_interval_we)
            min_interval_reg <= min_interval;
    end

    ecrl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .now_ms     (now_ms),
        .event_id   (event_id),
        .payload    (payload),
        .coalesce   (coalesce),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    ecrl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .min_interval    (min_interval_reg),
        .item_valid      (item_valid),
        .item            (item),
        .pop             (pop),
        .result_valid    (result_valid),
        .kind            (kind),
        .delay_ms        (delay_ms),
        .event_id_res    (event_id_res),
        .payload_out     (payload_out),
        .last            (last),
        .posted_count    (posted_count),
        .coalesced_count (coalesced_count),
        .dropped_count   (dropped_count),
        .delivered_count (delivered_count)
    );

    // A wake request is always the only result of its command
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_WAKE_REQ)) |-> last)
        else $error("wake request not marked last");

    // A delivery streams without gaps until its last event
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_EVENT) && !last)
        |=> (result_valid && (kind == KIND_EVENT)))
        else $error("gap inside a delivery");

    // A requested delay never exceeds the configured interval
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_WAKE_REQ)) |-> (delay_ms <= min_interval_reg))
        else $error("wake delay above min_interval");

endmodule
